### sv/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg: shared types and constants of the selective-repeat sender window
// Payload words, request/action/phase codes, controller-datapath structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srsw_pkg;

  // fixed field widths
  localparam int WINDOW_MAX = 64;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int LEN_BITS   = 12;
  localparam int SEQ_W      = 31;
  localparam int WIN_W      = 7;
  localparam int RETRY_W    = 4;
  localparam int REQ_W      = 3;
  localparam int ACT_W      = 3;
  localparam int PHASE_W    = 2;
  localparam int RAM_W      = SEQ_W + LEN_BITS;

  // remainder unit: padded dividend, bits retired per cycle
  localparam int MOD_W     = 32;
  localparam int MOD_DIG   = 4;
  localparam int MOD_CYC   = MOD_W / MOD_DIG;
  localparam int MOD_CNT_W = $clog2(MOD_CYC);

  // register file
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_WIN   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_START = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RETRY = 2'd2;

  localparam logic [WIN_W-1:0]   WIN_RST   = 7'd8;
  localparam logic [SEQ_W-1:0]   START_RST = 31'd1;
  localparam logic [RETRY_W-1:0] RETRY_RST = 4'd10;

  typedef enum logic [REQ_W-1:0] {
    REQ_START   = 3'd0,
    REQ_DATA    = 3'd1,
    REQ_EOF     = 3'd2,
    REQ_RDERR   = 3'd3,
    REQ_RR      = 3'd4,
    REQ_SREJ    = 3'd5,
    REQ_CORRUPT = 3'd6,
    REQ_TIMEOUT = 3'd7
  } req_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE      = 3'd0,
    ACT_NAME_OK   = 3'd1,
    ACT_NAME_BAD  = 3'd2,
    ACT_SEND_DATA = 3'd3,
    ACT_RESEND    = 3'd4,
    ACT_SEND_EOF  = 3'd5,
    ACT_FINISHED  = 3'd6
  } act_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE  = 2'd0,
    PH_SEND  = 2'd1,
    PH_BLOCK = 2'd2,
    PH_WAIT  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RETRY_KEEP = 2'd0,
    RETRY_CLR  = 2'd1,
    RETRY_ONE  = 2'd2,
    RETRY_INC  = 2'd3
  } retry_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_MOD  = 3'd1,
    ST_EXEC = 3'd2,
    ST_READ = 3'd3,
    ST_EMIT = 3'd4
  } ctl_state_e;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic                file_ok;
    logic [LEN_BITS-1:0] chunk_len;
    logic [SEQ_W-1:0]    ack_seq;
  } in_word_t;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [SEQ_W-1:0]    pkt_seq;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_BITS-1:0] pkt_len;
    logic [PHASE_W-1:0]  phase;
    logic                last;
  } out_word_t;

  typedef struct packed {
    logic   item_load;
    logic   sess_set;
    logic   rr_take;
    logic   inc_next;
    logic   ram_we;
    logic   wlen_zero;
    logic   rd_load;
    logic   rd_head;
    logic   phase_we;
    phase_e phase_d;
    retry_e retry_op;
    logic   out_load;
    act_e   out_act;
    logic   out_last;
  } cmd_t;

  typedef struct packed {
    req_e   req;
    phase_e phase;
    logic   file_ok;
    logic   len_zero;
    logic   rr_ok;
    logic   full_inc;
    logic   full_rr;
    logic   ack_eq_next;
    logic   retry_lt;
    logic   limit_nz;
    logic   mod_done;
    logic   out_free;
  } sts_t;

endpackage

`default_nettype wire

### sv/srsw_ram.sv
// ----------------------------------------------------------------------------
// srsw_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/srsw_mod.sv
// ----------------------------------------------------------------------------
// srsw_mod: iterative remainder unit
// Sequence number mod window size, restoring method, four bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsw_mod (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [srsw_pkg::SEQ_W-1:0]  dividend_i,
  input  wire logic [srsw_pkg::WIN_W-1:0]  divisor_i,
  output      logic                        done_o,
  output      logic [srsw_pkg::SLOT_W-1:0] rem_o
);

  logic                            busy_q;
  logic [srsw_pkg::MOD_CNT_W-1:0]  cnt_q;
  logic [srsw_pkg::MOD_W-1:0]      shf_q;
  logic [srsw_pkg::WIN_W-1:0]      div_q;
  logic [srsw_pkg::SLOT_W-1:0]     rem_q;
  logic [srsw_pkg::SLOT_W-1:0]     rem_d;
  logic [srsw_pkg::WIN_W-1:0]      acc;

  // partial remainder stays below the divisor, so it fits the slot width
  always_comb begin
    rem_d = rem_q;
    acc   = '0;
    for (int i = 0; i < srsw_pkg::MOD_DIG; i++) begin
      acc = {rem_d, shf_q[srsw_pkg::MOD_W-1-i]};
      if (acc >= div_q) begin
        acc = acc - div_q;
      end
      rem_d = acc[srsw_pkg::SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + srsw_pkg::MOD_CNT_W'(1);
      if (cnt_q == srsw_pkg::MOD_CNT_W'(srsw_pkg::MOD_CYC - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shf_q <= srsw_pkg::MOD_W'(dividend_i);
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      shf_q <= shf_q << srsw_pkg::MOD_DIG;
      rem_q <= rem_d;
    end
  end

  assign done_o = !busy_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### sv/srsw_dp.sv
// ----------------------------------------------------------------------------
// srsw_dp: sender window datapath
// Session registers, slot table, remainder unit, compares and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsw_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire srsw_pkg::in_word_t           in_word_i,
  input  wire logic [srsw_pkg::WIN_W-1:0]   win_size_i,
  input  wire logic [srsw_pkg::SEQ_W-1:0]   start_seq_i,
  input  wire logic [srsw_pkg::RETRY_W-1:0] retry_limit_i,
  input  wire srsw_pkg::cmd_t               cmd_i,
  output      srsw_pkg::sts_t               sts_o,
  input  wire logic                         out_stall_i,
  output      logic                         out_valid_o,
  output      srsw_pkg::out_word_t          out_word_o
);

  srsw_pkg::in_word_t            in_q;
  logic [srsw_pkg::SEQ_W-1:0]    next_q;
  logic [srsw_pkg::SEQ_W-1:0]    acked_q;
  logic [srsw_pkg::SLOT_W-1:0]   head_q;
  logic [srsw_pkg::RETRY_W-1:0]  retry_q;
  srsw_pkg::phase_e              phase_q;
  logic [srsw_pkg::SLOT_W-1:0]   rd_slot_q;
  logic                          out_valid_q;
  srsw_pkg::out_word_t           out_word_q;
  srsw_pkg::out_word_t           out_d;

  logic [srsw_pkg::WIN_W-1:0]    win;
  logic [srsw_pkg::SEQ_W-1:0]    mod_op;
  logic                          mod_done;
  logic [srsw_pkg::SLOT_W-1:0]   mod_rem;
  logic [srsw_pkg::RAM_W-1:0]    ram_wdata;
  logic [srsw_pkg::RAM_W-1:0]    ram_rdata;
  logic [srsw_pkg::SEQ_W-1:0]    out_cnt;
  logic [srsw_pkg::SEQ_W-1:0]    ack_dist;
  logic [srsw_pkg::SEQ_W-1:0]    rr_cnt;
  logic [srsw_pkg::SEQ_W-1:0]    win_ext;
  logic                          rr_ok;
  logic                          out_free;

  // window size used clamped to 1..max
  always_comb begin
    if (win_size_i == '0) begin
      win = srsw_pkg::WIN_W'(1);
    end else if (win_size_i > srsw_pkg::WIN_W'(srsw_pkg::WINDOW_MAX)) begin
      win = srsw_pkg::WIN_W'(srsw_pkg::WINDOW_MAX);
    end else begin
      win = win_size_i;
    end
  end

  // remainder operand picked from the incoming word
  always_comb begin
    unique case (srsw_pkg::req_e'(in_word_i.req_type)) inside
      srsw_pkg::REQ_START:                 mod_op = start_seq_i;
      srsw_pkg::REQ_RR, srsw_pkg::REQ_SREJ: mod_op = in_word_i.ack_seq;
      default:                             mod_op = next_q;
    endcase
  end

  srsw_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.item_load),
    .dividend_i (mod_op),
    .divisor_i  (win),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign ram_wdata = {next_q, cmd_i.wlen_zero ? {srsw_pkg::LEN_BITS{1'b0}} : in_q.chunk_len};

  srsw_ram #(
    .WIDTH (srsw_pkg::RAM_W),
    .DEPTH (srsw_pkg::WINDOW_MAX)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (mod_rem),
    .wdata_i (ram_wdata),
    .raddr_i (rd_slot_q),
    .rdata_o (ram_rdata)
  );

  // window arithmetic, all modulo 2^31
  assign out_cnt  = next_q - acked_q;
  assign ack_dist = in_q.ack_seq - acked_q;
  assign rr_ok    = (ack_dist != '0) && (ack_dist <= out_cnt);
  assign rr_cnt   = rr_ok ? (next_q - in_q.ack_seq) : out_cnt;
  assign win_ext  = srsw_pkg::SEQ_W'(win);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.req         = srsw_pkg::req_e'(in_q.req_type);
    sts_o.phase       = phase_q;
    sts_o.file_ok     = in_q.file_ok;
    sts_o.len_zero    = (in_q.chunk_len == '0);
    sts_o.rr_ok       = rr_ok;
    sts_o.full_inc    = (out_cnt + srsw_pkg::SEQ_W'(1)) >= win_ext;
    sts_o.full_rr     = rr_cnt >= win_ext;
    sts_o.ack_eq_next = (in_q.ack_seq == next_q);
    sts_o.retry_lt    = retry_q < retry_limit_i;
    sts_o.limit_nz    = (retry_limit_i != '0);
    sts_o.mod_done    = mod_done;
    sts_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      in_q <= in_word_i;
    end
    if (cmd_i.rd_load) begin
      rd_slot_q <= cmd_i.rd_head ? head_q : mod_rem;
    end
    if (cmd_i.out_load) begin
      out_word_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q  <= '0;
      acked_q <= '0;
      head_q  <= '0;
      retry_q <= '0;
      phase_q <= srsw_pkg::PH_IDLE;
    end else begin
      if (cmd_i.sess_set) begin
        next_q <= start_seq_i;
      end else if (cmd_i.inc_next) begin
        next_q <= next_q + srsw_pkg::SEQ_W'(1);
      end
      if (cmd_i.sess_set) begin
        acked_q <= start_seq_i - srsw_pkg::SEQ_W'(1);
      end else if (cmd_i.rr_take) begin
        acked_q <= in_q.ack_seq;
      end
      if (cmd_i.sess_set || cmd_i.rr_take) begin
        head_q <= mod_rem;
      end
      if (cmd_i.phase_we) begin
        phase_q <= cmd_i.phase_d;
      end
      case (cmd_i.retry_op)
        srsw_pkg::RETRY_CLR: retry_q <= '0;
        srsw_pkg::RETRY_ONE: retry_q <= srsw_pkg::RETRY_W'(1);
        srsw_pkg::RETRY_INC: retry_q <= retry_q + srsw_pkg::RETRY_W'(1);
        default:             retry_q <= retry_q;
      endcase
    end
  end

  // result word; phase is already final when a word is loaded
  always_comb begin
    out_d        = '0;
    out_d.action = cmd_i.out_act;
    out_d.phase  = phase_q;
    out_d.last   = cmd_i.out_last;
    case (cmd_i.out_act)
      srsw_pkg::ACT_SEND_DATA: begin
        out_d.pkt_seq = next_q;
        out_d.slot    = mod_rem;
        out_d.pkt_len = in_q.chunk_len;
      end
      srsw_pkg::ACT_SEND_EOF: begin
        out_d.pkt_seq = next_q;
        out_d.slot    = mod_rem;
      end
      srsw_pkg::ACT_RESEND: begin
        out_d.pkt_seq = ram_rdata[srsw_pkg::RAM_W-1:srsw_pkg::LEN_BITS];
        out_d.slot    = rd_slot_q;
        out_d.pkt_len = ram_rdata[srsw_pkg::LEN_BITS-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

### sv/srsw_ctrl.sv
// ----------------------------------------------------------------------------
// srsw_ctrl: sender window controller
// Sequences remainder, event decode, slot read and up to two result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsw_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_stall_o,
  input  wire srsw_pkg::sts_t sts_i,
  output      srsw_pkg::cmd_t cmd_o
);

  srsw_pkg::ctl_state_e state_q, state_d;
  srsw_pkg::act_e       act1_q, act1_d;
  srsw_pkg::act_e       act2_q, act2_d;
  logic                 two_q, two_d;
  logic                 sec_q, sec_d;
  srsw_pkg::act_e       cur_act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srsw_pkg::ST_IDLE;
      act1_q  <= srsw_pkg::ACT_NONE;
      act2_q  <= srsw_pkg::ACT_NONE;
      two_q   <= 1'b0;
      sec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      act1_q  <= act1_d;
      act2_q  <= act2_d;
      two_q   <= two_d;
      sec_q   <= sec_d;
    end
  end

  assign in_stall_o = (state_q != srsw_pkg::ST_IDLE);
  assign cur_act    = sec_q ? act2_q : act1_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    act1_d  = act1_q;
    act2_d  = act2_q;
    two_d   = two_q;
    sec_d   = sec_q;

    unique case (state_q)
      srsw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          sec_d           = 1'b0;
          state_d         = srsw_pkg::ST_MOD;
        end
      end

      srsw_pkg::ST_MOD: begin
        if (sts_i.mod_done) begin
          state_d = srsw_pkg::ST_EXEC;
        end
      end

      srsw_pkg::ST_EXEC: begin
        act1_d = srsw_pkg::ACT_NONE;
        act2_d = srsw_pkg::ACT_NONE;
        two_d  = 1'b0;
        unique case (sts_i.req) inside
          srsw_pkg::REQ_START: begin
            if (sts_i.phase == srsw_pkg::PH_IDLE) begin
              if (sts_i.file_ok) begin
                cmd_o.sess_set = 1'b1;
                cmd_o.phase_we = 1'b1;
                cmd_o.phase_d  = srsw_pkg::PH_SEND;
                cmd_o.retry_op = srsw_pkg::RETRY_CLR;
                act1_d         = srsw_pkg::ACT_NAME_OK;
              end else begin
                act1_d = srsw_pkg::ACT_NAME_BAD;
              end
            end
          end

          srsw_pkg::REQ_DATA, srsw_pkg::REQ_EOF: begin
            if (sts_i.phase == srsw_pkg::PH_SEND) begin
              cmd_o.ram_we = 1'b1;
              // an empty chunk closes the file like an explicit eof
              if (sts_i.req == srsw_pkg::REQ_EOF || sts_i.len_zero) begin
                cmd_o.wlen_zero = 1'b1;
                cmd_o.phase_we  = 1'b1;
                cmd_o.phase_d   = srsw_pkg::PH_WAIT;
                cmd_o.retry_op  = srsw_pkg::RETRY_CLR;
                act1_d          = srsw_pkg::ACT_SEND_EOF;
              end else begin
                act1_d = srsw_pkg::ACT_SEND_DATA;
                if (sts_i.full_inc) begin
                  // window filled: first head resend counts as a retry
                  two_d          = 1'b1;
                  cmd_o.phase_we = 1'b1;
                  if (sts_i.limit_nz) begin
                    cmd_o.phase_d  = srsw_pkg::PH_BLOCK;
                    cmd_o.retry_op = srsw_pkg::RETRY_ONE;
                    cmd_o.rd_load  = 1'b1;
                    cmd_o.rd_head  = 1'b1;
                    act2_d         = srsw_pkg::ACT_RESEND;
                  end else begin
                    cmd_o.phase_d  = srsw_pkg::PH_IDLE;
                    cmd_o.retry_op = srsw_pkg::RETRY_CLR;
                    act2_d         = srsw_pkg::ACT_FINISHED;
                  end
                end
              end
            end
          end

          srsw_pkg::REQ_RDERR: begin
            if (sts_i.phase == srsw_pkg::PH_SEND) begin
              cmd_o.phase_we = 1'b1;
              cmd_o.phase_d  = srsw_pkg::PH_IDLE;
              cmd_o.retry_op = srsw_pkg::RETRY_CLR;
              act1_d         = srsw_pkg::ACT_FINISHED;
            end
          end

          srsw_pkg::REQ_RR: begin
            if (sts_i.phase == srsw_pkg::PH_WAIT && sts_i.ack_eq_next) begin
              cmd_o.phase_we = 1'b1;
              cmd_o.phase_d  = srsw_pkg::PH_IDLE;
              cmd_o.retry_op = srsw_pkg::RETRY_CLR;
              act1_d         = srsw_pkg::ACT_FINISHED;
            end else if (sts_i.phase != srsw_pkg::PH_IDLE) begin
              cmd_o.rr_take  = sts_i.rr_ok;
              cmd_o.retry_op = srsw_pkg::RETRY_CLR;
              if (sts_i.phase == srsw_pkg::PH_BLOCK && !sts_i.full_rr) begin
                cmd_o.phase_we = 1'b1;
                cmd_o.phase_d  = srsw_pkg::PH_SEND;
              end
            end
          end

          srsw_pkg::REQ_SREJ: begin
            if (sts_i.phase != srsw_pkg::PH_IDLE) begin
              cmd_o.rd_load  = 1'b1;
              cmd_o.retry_op = srsw_pkg::RETRY_CLR;
              act1_d         = srsw_pkg::ACT_RESEND;
            end
          end

          srsw_pkg::REQ_TIMEOUT: begin
            if (sts_i.phase == srsw_pkg::PH_BLOCK || sts_i.phase == srsw_pkg::PH_WAIT) begin
              if (!sts_i.retry_lt) begin
                cmd_o.phase_we = 1'b1;
                cmd_o.phase_d  = srsw_pkg::PH_IDLE;
                cmd_o.retry_op = srsw_pkg::RETRY_CLR;
                act1_d         = srsw_pkg::ACT_FINISHED;
              end else if (sts_i.phase == srsw_pkg::PH_BLOCK) begin
                cmd_o.rd_load  = 1'b1;
                cmd_o.rd_head  = 1'b1;
                cmd_o.retry_op = srsw_pkg::RETRY_INC;
                act1_d         = srsw_pkg::ACT_RESEND;
              end else begin
                cmd_o.ram_we    = 1'b1;
                cmd_o.wlen_zero = 1'b1;
                cmd_o.retry_op  = srsw_pkg::RETRY_INC;
                act1_d          = srsw_pkg::ACT_SEND_EOF;
              end
            end
          end

          default: ;
        endcase
        state_d = (act1_d == srsw_pkg::ACT_RESEND) ? srsw_pkg::ST_READ : srsw_pkg::ST_EMIT;
      end

      srsw_pkg::ST_READ: begin
        state_d = srsw_pkg::ST_EMIT;
      end

      srsw_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_act  = cur_act;
          cmd_o.out_last = sec_q || !two_q;
          cmd_o.inc_next = (cur_act == srsw_pkg::ACT_SEND_DATA);
          if (!sec_q && two_q) begin
            sec_d   = 1'b1;
            state_d = (act2_q == srsw_pkg::ACT_RESEND) ? srsw_pkg::ST_READ
                                                       : srsw_pkg::ST_EMIT;
          end else begin
            state_d = srsw_pkg::ST_IDLE;
          end
        end
      end

      default: state_d = srsw_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### sv/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window: selective-repeat sender window controller
// The first result word loads once the remainder is done and the event decoded;
// a slot resend reads the slot table first. A second word follows the first, after
// another slot read for a head resend. One item is in work at a time; an output
// stall holds it, and the remainder unit retires 4 bits of the sequence per cycle.
// Reset clears the session state and loads the register defaults; the slot
// table is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_sender_window (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire srsw_pkg::in_word_t            in_word_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      srsw_pkg::out_word_t           out_word_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [srsw_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [srsw_pkg::PDATA_W-1:0]  pwdata,
  output      logic [srsw_pkg::PDATA_W-1:0]  prdata,
  output      logic                          pready
);

  logic [srsw_pkg::WIN_W-1:0]   win_q;
  logic [srsw_pkg::SEQ_W-1:0]   start_q;
  logic [srsw_pkg::RETRY_W-1:0] limit_q;
  logic [srsw_pkg::REG_IDX_W-1:0] reg_idx;

  srsw_pkg::cmd_t cmd;
  srsw_pkg::sts_t sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[srsw_pkg::PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= srsw_pkg::WIN_RST;
      start_q <= srsw_pkg::START_RST;
      limit_q <= srsw_pkg::RETRY_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        srsw_pkg::REG_WIN:   win_q   <= pwdata[srsw_pkg::WIN_W-1:0];
        srsw_pkg::REG_START: start_q <= pwdata[srsw_pkg::SEQ_W-1:0];
        srsw_pkg::REG_RETRY: limit_q <= pwdata[srsw_pkg::RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      srsw_pkg::REG_WIN:   prdata = srsw_pkg::PDATA_W'(win_q);
      srsw_pkg::REG_START: prdata = srsw_pkg::PDATA_W'(start_q);
      srsw_pkg::REG_RETRY: prdata = srsw_pkg::PDATA_W'(limit_q);
      default:             prdata = '0;
    endcase
  end

  srsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srsw_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_word_i     (in_word_i),
    .win_size_i    (win_q),
    .start_seq_i   (start_q),
    .retry_limit_i (limit_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_word_o    (out_word_o)
  );

  // one item in work at a time
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input word accepted while an item is in work");

  // slot writes use the remainder, which must be settled
  a_write_after_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ram_we |-> sts.mod_done)
    else $error("slot table written before remainder is done");

  // the last word of an item frees the input side
  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && cmd.out_last) |=> !in_stall_o)
    else $error("input still stalled after the last word of an item");

  // a word is loaded only into a free output register
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire
